[design/regex_style_pretokenizer_macros.svh]
// Assertion macros used by the pretokenizer top level.
`ifndef REGEX_STYLE_PRETOKENIZER_MACROS_SVH
`define REGEX_STYLE_PRETOKENIZER_MACROS_SVH

// Condition a implies condition b in the same cycle, outside reset.
`define RGX_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("pretokenizer check failed");

// Condition a implies condition b in the following cycle, outside reset.
`define RGX_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("pretokenizer check failed");

// Condition b holds in the cycle after reset is applied.
`define RGX_ASSERT_AFTER_RESET(lbl, clk, rst, b) \
   lbl: assert property (@(posedge clk) (rst) |=> (b)) \
      else $error("pretokenizer check failed");

`endif

[design/rgxpt_pkg.sv]
// Types, constants and byte classification shared by the pretokenizer modules.
`timescale 1ns / 1ps

package rgxpt_pkg;

   // Sizes of the block.
   localparam int MAX_TEXT_DEFAULT = 65536;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_IDX_W      = 2;
   localparam int QUEUE_CNT_W      = 3;
   localparam int OUT_DEPTH        = 4;
   localparam int OUT_PTR_W        = 2;
   localparam int OUT_CNT_W        = 3;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int LIMIT_W          = 17;
   localparam int POS_W            = 17;
   localparam int OFFSET_W         = 16;

   // Register map.
   localparam logic [0:0] REG_SPAN_LIMIT = 1'b0;
   localparam logic [LIMIT_W-1:0] SPAN_LIMIT_RESET = 17'h10000;

   // Kinds of open run.
   localparam logic [1:0] RUN_NONE   = 2'd0;
   localparam logic [1:0] RUN_LETTER = 2'd1;
   localparam logic [1:0] RUN_DIGIT  = 2'd2;
   localparam logic [1:0] RUN_WS     = 2'd3;

   localparam logic [1:0] MAX_DIGITS = 2'd3;

   // Character codes.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_A_LOWER = 8'h61;
   localparam logic [7:0] CH_Z_LOWER = 8'h7A;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_E       = 8'h65;
   localparam logic [7:0] CH_L       = 8'h6C;
   localparam logic [7:0] CH_M       = 8'h6D;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_V       = 8'h76;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;

   // One input item.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [15:0] span_offset;
      logic [16:0] span_length;
      logic        last_span;
   } rsp_item_type;

   // Classified text byte as held in the queue between front and back.
   typedef struct packed {
      logic       is_letter;
      logic       is_digit;
      logic       is_ws;
      logic       is_apos;
      logic       is_space;
      logic       is_short;
      logic       fold_r;
      logic       fold_v;
      logic       fold_l;
      logic       fold_e;
      logic [1:0] extra;
      logic       is_end;
   } byte_info_type;

   // The three oldest queue entries and the fill level, as the back sees them.
   typedef struct packed {
      byte_info_type [2:0]    entry;
      logic [QUEUE_CNT_W-1:0] fill;
   } queue_view_type;

   // Spans written into the result queue in the same cycle, oldest in slot 0.
   typedef struct packed {
      logic [1:0]         count;
      rsp_item_type [1:0] span;
   } emit_type;

   // Works out everything the scanner needs to know about one byte.
   function automatic byte_info_type classify(input logic [7:0] b, input logic at_end);
      byte_info_type info;
      logic [7:0]    folded;
      folded         = b | CASE_BIT;
      info.is_letter = b[7] || (folded >= CH_A_LOWER && folded <= CH_Z_LOWER);
      info.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
      info.is_ws     = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
      info.is_apos   = (b == CH_APOS);
      info.is_space  = (b == CH_SPACE);
      info.is_short  = (folded == CH_S) || (folded == CH_T) || (folded == CH_M) ||
                       (folded == CH_D);
      info.fold_r    = (folded == CH_R);
      info.fold_v    = (folded == CH_V);
      info.fold_l    = (folded == CH_L);
      info.fold_e    = (folded == CH_E);
      priority if (!b[7]) begin
         info.extra = 2'd0;
      end else if (b < LEAD_THREE) begin
         info.extra = 2'd1;
      end else if (b < LEAD_FOUR) begin
         info.extra = 2'd2;
      end else begin
         info.extra = 2'd3;
      end
      info.is_end = at_end;
      return info;
   endfunction

   // Packs the fields of one result item.
   function automatic rsp_item_type make_span(input logic [15:0] off,
                                              input logic [16:0] len,
                                              input logic last);
      rsp_item_type s;
      s.span_offset = off;
      s.span_length = len;
      s.last_span   = last;
      return s;
   endfunction

endpackage

[design/rgxpt_front.sv]
// Front part: accepts text bytes, tracks the text length, classifies and queues bytes.
`timescale 1ns / 1ps

module rgxpt_front #(
   parameter int MAX_TEXT = rgxpt_pkg::MAX_TEXT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  rgxpt_pkg::req_item_type   req_data,
   input  logic [1:0]                pop_count,
   output rgxpt_pkg::queue_view_type view
);

   localparam int CNT_W = $clog2(MAX_TEXT);
   localparam int IDX_W = rgxpt_pkg::QUEUE_IDX_W;
   localparam int QCW   = rgxpt_pkg::QUEUE_CNT_W;
   localparam int DEPTH = rgxpt_pkg::QUEUE_DEPTH;
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_TEXT - 1);

   rgxpt_pkg::byte_info_type entry_ff [DEPTH];
   rgxpt_pkg::byte_info_type entry_in [DEPTH];
   logic [QCW-1:0]   fill_ff, fill_in, remain;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             trunc_ff, trunc_in;
   logic             accept, store, at_end;

   // An item is stored unless the text already ran past its maximum length.
   assign full   = (fill_ff == QCW'(DEPTH));
   assign accept = push && !full;
   assign store  = accept && !trunc_ff;
   assign at_end = req_data.last_byte || (count_ff == LAST_POS);
   assign remain = fill_ff - QCW'(pop_count);

   // Shift out the bytes the back consumed and append the new byte.
   always_comb begin
      entry_in = entry_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (i + int'(pop_count) < DEPTH) begin
            entry_in[i] = entry_ff[IDX_W'(i + int'(pop_count))];
         end
      end
      if (store) begin
         entry_in[remain[IDX_W-1:0]] = rgxpt_pkg::classify(req_data.text_byte, at_end);
      end
      fill_in = remain + QCW'(store);
   end

   // Byte counter within the text; bytes past the length limit are dropped.
   always_comb begin
      count_in = count_ff;
      trunc_in = trunc_ff;
      if (store) begin
         if (at_end) begin
            count_in = '0;
            trunc_in = !req_data.last_byte;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (accept && req_data.last_byte) begin
         trunc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         trunc_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         trunc_ff <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // The back looks at the three oldest entries.
   always_comb begin
      view.fill = fill_ff;
      for (int i = 0; i < 3; i++) begin
         view.entry[i] = entry_ff[i];
      end
   end

endmodule

[design/rgxpt_scan.sv]
// Back part: scans classified bytes, tracks the open run and emits spans.
`timescale 1ns / 1ps

module rgxpt_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  rgxpt_pkg::queue_view_type view,
   input  logic [16:0]               span_limit,
   input  logic                      room,
   output logic [1:0]                pop_count,
   output rgxpt_pkg::emit_type       emit
);

   localparam int PW = rgxpt_pkg::POS_W;

   logic [1:0]    kind_ff, kind_in;
   logic [PW-1:0] start_ff, start_in;
   logic [1:0]    digits_ff, digits_in;
   logic [1:0]    skip_ff, skip_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [16:0]   spans_ff, spans_in;

   rgxpt_pkg::byte_info_type e0, e1, e2;
   logic       have1, have2, go, done;
   logic       cont, term, halt, text_end, b_emit, slot;
   logic [1:0] b_len;

   assign e0    = view.entry[0];
   assign e1    = view.entry[1];
   assign e2    = view.entry[2];
   assign have1 = (view.fill >= 3'd2);
   assign have2 = (view.fill >= 3'd3);
   assign go    = (view.fill != '0) && room;
   assign done  = (spans_ff >= span_limit);

   always_comb begin
      kind_in   = kind_ff;
      start_in  = start_ff;
      digits_in = digits_ff;
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      spans_in  = spans_ff;
      pop_count = 2'd0;
      emit      = '0;
      cont      = 1'b0;
      term      = 1'b0;
      halt      = 1'b0;
      text_end  = 1'b0;
      b_emit    = 1'b0;
      b_len     = 2'd1;
      slot      = 1'b0;
      if (go) begin
         if (done) begin
            // Span limit reached: drop bytes up to the end of the text.
            pop_count = 2'd1;
            text_end  = e0.is_end;
         end else begin
            // Does the head byte extend the open run?
            unique case (kind_ff)
               rgxpt_pkg::RUN_LETTER: begin
                  if (skip_ff != 2'd0) begin
                     skip_in = skip_ff - 2'd1;
                     cont    = 1'b1;
                  end else if (e0.is_letter) begin
                     skip_in = e0.extra;
                     cont    = 1'b1;
                  end else begin
                     term = 1'b1;
                  end
               end
               rgxpt_pkg::RUN_DIGIT: begin
                  if (e0.is_digit && digits_ff != rgxpt_pkg::MAX_DIGITS) begin
                     digits_in = digits_ff + 2'd1;
                     cont      = 1'b1;
                  end else begin
                     term = 1'b1;
                  end
               end
               rgxpt_pkg::RUN_WS: begin
                  if (e0.is_ws) begin
                     cont = 1'b1;
                  end else begin
                     term = 1'b1;
                  end
               end
               rgxpt_pkg::RUN_NONE: begin
               end
            endcase

            if (cont) begin
               // Run goes on; at the text end it is flushed, clamped there.
               pop_count = 2'd1;
               if (e0.is_end) begin
                  emit.span[0] = rgxpt_pkg::make_span(start_ff[15:0],
                                                      pos_ff + 17'd1 - start_ff, 1'b1);
                  emit.count   = 2'd1;
                  spans_in     = spans_ff + 17'd1;
                  text_end     = 1'b1;
               end
            end else begin
               // Otherwise the head byte closes any open run.
               if (term) begin
                  emit.span[0] = rgxpt_pkg::make_span(start_ff[15:0], pos_ff - start_ff,
                                                      spans_ff + 17'd1 == span_limit);
                  emit.count   = 2'd1;
                  spans_in     = spans_ff + 17'd1;
                  kind_in      = rgxpt_pkg::RUN_NONE;
                  halt         = (spans_ff + 17'd1 == span_limit);
                  slot         = 1'b1;
               end
               // With no run open, start whatever the head byte begins.
               if (!halt) begin
                  priority if (e0.is_apos) begin
                     priority if (!e0.is_end && !have1) begin
                        pop_count = 2'd0;
                     end else if (!e0.is_end && e1.is_short) begin
                        b_emit    = 1'b1;
                        b_len     = 2'd2;
                        pop_count = 2'd2;
                        text_end  = e1.is_end;
                     end else if (!e0.is_end && !e1.is_end && !have2) begin
                        pop_count = 2'd0;
                     end else if (!e0.is_end && !e1.is_end &&
                                  ((e1.fold_r && e2.fold_e) || (e1.fold_v && e2.fold_e) ||
                                   (e1.fold_l && e2.fold_l))) begin
                        b_emit    = 1'b1;
                        b_len     = 2'd3;
                        pop_count = 2'd3;
                        text_end  = e2.is_end;
                     end else begin
                        b_emit    = 1'b1;
                        pop_count = 2'd1;
                        text_end  = e0.is_end;
                     end
                  end else if (e0.is_space) begin
                     if (e0.is_end || have1) begin
                        start_in  = pos_ff;
                        pop_count = 2'd1;
                        priority if (!e0.is_end && e1.is_letter) begin
                           kind_in = rgxpt_pkg::RUN_LETTER;
                           skip_in = 2'd0;
                        end else if (!e0.is_end && e1.is_digit) begin
                           kind_in   = rgxpt_pkg::RUN_DIGIT;
                           digits_in = 2'd0;
                        end else begin
                           kind_in = rgxpt_pkg::RUN_WS;
                        end
                        b_emit   = e0.is_end;
                        text_end = e0.is_end;
                     end
                  end else if (e0.is_letter || e0.is_digit || e0.is_ws) begin
                     start_in  = pos_ff;
                     pop_count = 2'd1;
                     priority if (e0.is_letter) begin
                        kind_in = rgxpt_pkg::RUN_LETTER;
                        skip_in = e0.extra;
                     end else if (e0.is_digit) begin
                        kind_in   = rgxpt_pkg::RUN_DIGIT;
                        digits_in = 2'd1;
                     end else begin
                        kind_in = rgxpt_pkg::RUN_WS;
                     end
                     b_emit   = e0.is_end;
                     text_end = e0.is_end;
                  end else begin
                     b_emit    = 1'b1;
                     pop_count = 2'd1;
                     text_end  = e0.is_end;
                  end
               end
               // A span that starts at the head byte.
               if (b_emit) begin
                  emit.span[slot] = rgxpt_pkg::make_span(pos_ff[15:0], 17'(b_len),
                                                         spans_in + 17'd1 == span_limit);
                  emit.count      = emit.count + 2'd1;
                  spans_in        = spans_in + 17'd1;
               end
            end
         end

         // The final span of a text is flagged, and the text state is cleared.
         if (text_end) begin
            if (emit.count == 2'd2) begin
               emit.span[1].last_span = 1'b1;
            end else if (emit.count == 2'd1) begin
               emit.span[0].last_span = 1'b1;
            end
            kind_in   = rgxpt_pkg::RUN_NONE;
            start_in  = '0;
            digits_in = 2'd0;
            skip_in   = 2'd0;
            pos_in    = '0;
            spans_in  = '0;
         end else begin
            pos_in = pos_ff + PW'(pop_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= rgxpt_pkg::RUN_NONE;
         start_ff  <= '0;
         digits_ff <= 2'd0;
         skip_ff   <= 2'd0;
         pos_ff    <= '0;
         spans_ff  <= '0;
      end else begin
         kind_ff   <= kind_in;
         start_ff  <= start_in;
         digits_ff <= digits_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         spans_ff  <= spans_in;
      end
   end

endmodule

[design/rgxpt_span_fifo.sv]
// Result queue: takes up to two spans a cycle and hands out one span a cycle on pop.
`timescale 1ns / 1ps

module rgxpt_span_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  rgxpt_pkg::emit_type     emit,
   input  logic                    pop,
   output logic                    empty,
   output logic                    room,
   output rgxpt_pkg::rsp_item_type rsp_data
);

   localparam int PTR_W = rgxpt_pkg::OUT_PTR_W;
   localparam int CNT_W = rgxpt_pkg::OUT_CNT_W;
   localparam int DEPTH = rgxpt_pkg::OUT_DEPTH;

   rgxpt_pkg::rsp_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             take;

   assign empty    = (count_ff == '0);
   assign room     = (count_ff <= CNT_W'(DEPTH - 2));
   assign take     = pop && !empty;
   assign rsp_data = slot_ff[rd_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = wr_ff + PTR_W'(emit.count);
      rd_in    = rd_ff + PTR_W'(take);
      count_in = count_ff + CNT_W'(emit.count) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the new spans in arrival order.
   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         slot_ff[wr_ff] <= emit.span[0];
      end
      if (emit.count == 2'd2) begin
         slot_ff[wr_ff + PTR_W'(1)] <= emit.span[1];
      end
   end

endmodule

[design/regex_style_pretokenizer.sv]
// Top level of the pretokenizer: register port, front, scanner and result queue.
`timescale 1ns / 1ps

// Streaming pretokenizer that cuts text into spans (contractions, letter runs,
// digit groups, whitespace runs, single bytes) and reports offset and length.
// Input: one text byte per item over push/full; last_byte closes the text.
// Results: spans over empty/pop, oldest first; last_span marks the final span
// of a text and the span that reaches the span limit.
// Throughput: one byte per cycle sustained while full is low; the scanner
// consumes up to three queued bytes a cycle and writes up to two spans a cycle
// into a four-entry result queue that drains one span a cycle while popped.
// With both queues empty, the byte that decides a span is registered in the byte
// queue, the scanner emits the span, and the result queue registers it onto the
// result ports. A run waits for the byte after its end, an apostrophe waits for up
// to two following bytes and a space for one, unless the text ends first.
// When the receiver stalls, the result queue fills, the scanner holds, and
// full rises once the four-entry byte queue is full.
// Reset clears all text state, empties both queues and sets the span limit
// to 65536. The span limit register sits at byte address 0.
module regex_style_pretokenizer #(
   parameter int MAX_TEXT = rgxpt_pkg::MAX_TEXT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  rgxpt_pkg::req_item_type              req_data,
   output logic                                 empty,
   input  logic                                 pop,
   output rgxpt_pkg::rsp_item_type              rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rgxpt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rgxpt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rgxpt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);

`include "regex_style_pretokenizer_macros.svh"

   localparam int DW = rgxpt_pkg::CSR_DATA_W;
   localparam int AW = rgxpt_pkg::CSR_ADDR_W;

   logic [rgxpt_pkg::LIMIT_W-1:0] span_limit_ff, span_limit_in;
   logic                      csr_write;
   logic [AW-3:0]             csr_index;
   rgxpt_pkg::queue_view_type view;
   rgxpt_pkg::emit_type       emit;
   logic [1:0]                pop_count;
   logic                      room;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[AW-1:2];
   assign prdata    = (csr_index == rgxpt_pkg::REG_SPAN_LIMIT) ? DW'(span_limit_ff) : '0;

   always_comb begin
      span_limit_in = span_limit_ff;
      if (csr_write && csr_index == rgxpt_pkg::REG_SPAN_LIMIT) begin
         span_limit_in = pwdata[rgxpt_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_limit_ff <= rgxpt_pkg::SPAN_LIMIT_RESET;
      end else begin
         span_limit_ff <= span_limit_in;
      end
   end

   // Byte intake and classification.
   rgxpt_front #(
      .MAX_TEXT (MAX_TEXT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .pop_count (pop_count),
      .view      (view)
   );

   // Span scanner.
   rgxpt_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .view       (view),
      .span_limit (span_limit_ff),
      .room       (room),
      .pop_count  (pop_count),
      .emit       (emit)
   );

   // Result queue.
   rgxpt_span_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .pop      (pop),
      .empty    (empty),
      .room     (room),
      .rsp_data (rsp_data)
   );

   // Checks on the cooperation of the parts.
   `RGX_ASSERT_IMPLY(a_length_nonzero, clock, reset, !empty, rsp_data.span_length != '0)
   `RGX_ASSERT_IMPLY(a_pop_in_queue, clock, reset, pop_count != 2'd0, pop_count <= view.fill)
   `RGX_ASSERT_IMPLY(a_emit_has_room, clock, reset, emit.count != 2'd0, room)
   `RGX_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, empty && !full)

endmodule

[test/regex_style_pretokenizer_tb.sv]
// Self-checking testbench for the regex-style pretokenizer: span prediction and checking.
`timescale 1ns / 1ps

module regex_style_pretokenizer_tb;

   localparam int          TEXT_CAP     = rgxpt_pkg::MAX_TEXT_DEFAULT;
   localparam int          MAX_PER_BYTE = 3;
   localparam int          QUIET_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;

   // Span predictor and the spans it still expects, oldest first.
   class span_scoreboard;
      rgxpt_pkg::rsp_item_type spans_due[$];
      int unsigned  errors;
      logic [16:0]  limit_now;
      int unsigned  text_pos;
      logic [1:0]   open_run;
      int unsigned  run_head;
      int unsigned  digits_seen;
      int unsigned  cont_left;
      logic [7:0]   held[2];
      int unsigned  held_n;
      int unsigned  spans_out;
      int unsigned  spans_now;

      function new();
         errors    = 0;
         limit_now = rgxpt_pkg::SPAN_LIMIT_RESET;
         clear_text();
      endfunction

      function void clear_text();
         text_pos    = 0;
         open_run    = rgxpt_pkg::RUN_NONE;
         run_head    = 0;
         digits_seen = 0;
         cont_left   = 0;
         held[0]     = '0;
         held[1]     = '0;
         held_n      = 0;
         spans_out   = 0;
      endfunction

      function void set_span_limit(logic [16:0] value);
         limit_now = value;
      endfunction

      function bit letter(logic [7:0] c);
         return c[7] || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit digit(logic [7:0] c);
         return c >= rgxpt_pkg::CH_ZERO && c <= rgxpt_pkg::CH_NINE;
      endfunction

      function bit blank(logic [7:0] c);
         return c == rgxpt_pkg::CH_SPACE || c == rgxpt_pkg::CH_TAB ||
                c == rgxpt_pkg::CH_LF || c == rgxpt_pkg::CH_CR;
      endfunction

      function int unsigned cont_bytes(logic [7:0] c);
         if (!c[7]) return 0;
         if (c < rgxpt_pkg::LEAD_THREE) return 1;
         if (c < rgxpt_pkg::LEAD_FOUR) return 2;
         return 3;
      endfunction

      function bit short_tail(logic [7:0] c);
         logic [7:0] f;
         f = c | rgxpt_pkg::CASE_BIT;
         return f == rgxpt_pkg::CH_S || f == rgxpt_pkg::CH_T || f == rgxpt_pkg::CH_M ||
                f == rgxpt_pkg::CH_D;
      endfunction

      function bit long_tail(logic [7:0] a, logic [7:0] b);
         logic [7:0] x, y;
         x = a | rgxpt_pkg::CASE_BIT;
         y = b | rgxpt_pkg::CASE_BIT;
         return (x == rgxpt_pkg::CH_R && y == rgxpt_pkg::CH_E) ||
                (x == rgxpt_pkg::CH_V && y == rgxpt_pkg::CH_E) ||
                (x == rgxpt_pkg::CH_L && y == rgxpt_pkg::CH_L);
      endfunction

      // Queues one span unless the limit or the per-byte bound stops it.
      function bit emit(int unsigned off, int unsigned len);
         rgxpt_pkg::rsp_item_type s;
         if (spans_out >= limit_now || spans_now >= MAX_PER_BYTE) return 1'b1;
         spans_out++;
         s.span_offset = 16'(off);
         s.span_length = 17'(len);
         s.last_span   = spans_out >= limit_now;
         spans_due.push_back(s);
         spans_now++;
         return spans_out >= limit_now;
      endfunction

      // Works out the spans that one accepted text byte completes.
      function void note_byte(rgxpt_pkg::req_item_type item);
         logic [7:0]   w[3];
         logic [7:0]   c;
         rgxpt_pkg::rsp_item_type tail;
         int unsigned  wn, k, head, pos, avail;
         bit           at_close, stop;
         spans_now = 0;
         k         = 0;
         stop      = 1'b0;
         if (spans_out >= limit_now || text_pos >= TEXT_CAP) begin
            if (item.last_byte) clear_text();
            return;
         end
         at_close = item.last_byte || (text_pos + 1 >= TEXT_CAP);
         wn       = held_n;
         w[0]     = held[0];
         w[1]     = held[1];
         w[2]     = '0;
         head     = text_pos - wn;
         w[wn]    = item.text_byte;
         wn++;
         text_pos++;

         while (k < wn && !stop) begin
            c     = w[k];
            avail = wn - k;
            pos   = head + k;
            if (open_run == rgxpt_pkg::RUN_LETTER) begin
               if (cont_left > 0) begin
                  cont_left--;
                  k++;
               end else if (letter(c)) begin
                  cont_left = cont_bytes(c);
                  k++;
               end else begin
                  open_run = rgxpt_pkg::RUN_NONE;
                  stop     = emit(run_head, pos - run_head);
               end
            end else if (open_run == rgxpt_pkg::RUN_DIGIT) begin
               if (digit(c) && digits_seen < 3) begin
                  digits_seen++;
                  k++;
               end else begin
                  open_run = rgxpt_pkg::RUN_NONE;
                  stop     = emit(run_head, pos - run_head);
               end
            end else if (open_run == rgxpt_pkg::RUN_WS) begin
               if (blank(c)) begin
                  k++;
               end else begin
                  open_run = rgxpt_pkg::RUN_NONE;
                  stop     = emit(run_head, pos - run_head);
               end
            end else if (c == rgxpt_pkg::CH_APOS) begin
               // A contraction needs up to two more bytes unless the text ends here.
               if (avail < 2 && !at_close) break;
               if (avail >= 2 && short_tail(w[k+1])) begin
                  stop = emit(pos, 2);
                  k += 2;
               end else if (avail == 2 && !at_close) begin
                  break;
               end else if (avail >= 3 && long_tail(w[k+1], w[k+2])) begin
                  stop = emit(pos, 3);
                  k += 3;
               end else begin
                  stop = emit(pos, 1);
                  k++;
               end
            end else if (c == rgxpt_pkg::CH_SPACE) begin
               // A space joins the following letter or digit run when there is one.
               if (avail < 2 && !at_close) break;
               run_head = pos;
               if (avail >= 2 && letter(w[k+1])) begin
                  open_run  = rgxpt_pkg::RUN_LETTER;
                  cont_left = 0;
               end else if (avail >= 2 && digit(w[k+1])) begin
                  open_run    = rgxpt_pkg::RUN_DIGIT;
                  digits_seen = 0;
               end else begin
                  open_run = rgxpt_pkg::RUN_WS;
               end
               k++;
            end else begin
               run_head = pos;
               if (letter(c)) begin
                  open_run  = rgxpt_pkg::RUN_LETTER;
                  cont_left = 0;
               end else if (digit(c)) begin
                  open_run    = rgxpt_pkg::RUN_DIGIT;
                  digits_seen = 0;
               end else if (blank(c)) begin
                  open_run = rgxpt_pkg::RUN_WS;
               end else begin
                  stop = emit(pos, 1);
                  k++;
               end
            end
         end

         if (stop) begin
            if (item.last_byte) clear_text();
            return;
         end

         held_n = 0;
         for (; k < wn && held_n < 2; k++) begin
            held[held_n] = w[k];
            held_n++;
         end

         // At the end of the text the open run is flushed and the last span marked.
         if (at_close) begin
            if (open_run != rgxpt_pkg::RUN_NONE) void'(emit(run_head, head + wn - run_head));
            if (spans_now > 0) begin
               tail           = spans_due.pop_back();
               tail.last_span = 1'b1;
               spans_due.push_back(tail);
            end
            if (item.last_byte) begin
               clear_text();
            end else begin
               open_run    = rgxpt_pkg::RUN_NONE;
               cont_left   = 0;
               digits_seen = 0;
               held_n      = 0;
               text_pos    = TEXT_CAP;
            end
         end
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%s mismatch: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      // Compares one span from the block with the oldest expected span.
      task check_span(rgxpt_pkg::rsp_item_type got);
         rgxpt_pkg::rsp_item_type want;
         if (spans_due.size() == 0) begin
            report("unexpected span, offset", got.span_offset, '0);
            return;
         end
         want = spans_due.pop_front();
         if (got.span_offset !== want.span_offset)
            report("span_offset", got.span_offset, want.span_offset);
         if (got.span_length !== want.span_length)
            report("span_length", got.span_length, want.span_length);
         if (got.last_span !== want.last_span)
            report("last_span", got.last_span, want.last_span);
      endtask
   endclass

   logic         clock   = 1'b0;
   logic         reset   = 1'b1;
   logic         push    = 1'b0;
   logic         full;
   rgxpt_pkg::req_item_type req_data = '0;
   logic         empty;
   logic         pop     = 1'b0;
   rgxpt_pkg::rsp_item_type rsp_data;
   logic         psel    = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite  = 1'b0;
   logic [rgxpt_pkg::CSR_ADDR_W-1:0] paddr  = '0;
   logic [rgxpt_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [rgxpt_pkg::CSR_DATA_W-1:0] prdata;
   logic         pready;

   span_scoreboard sb;
   logic [7:0]     text_buf[$];
   int unsigned    burst_left = 0;
   int unsigned    gap_max    = 0;
   int unsigned    burst_max  = 16;
   int unsigned    stall_pct  = 0;
   int unsigned    stall_max  = 1;
   int unsigned    hold_left  = 0;
   int unsigned    cycle_count = 0;

   regex_style_pretokenizer #(
      .MAX_TEXT(TEXT_CAP)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver pops freely and now and then stalls for a random stretch.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else begin
         pop <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) hold_left = $urandom_range(1, stall_max);
      end
   end

   // Accepted results are checked and accepted items are predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (!empty && pop) sb.check_span(rsp_data);
         if (push && !full) sb.note_byte(req_data);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("regex_style_pretokenizer regression: fail");
      $finish;
   end

   function automatic logic [7:0] mixed_case(logic [7:0] c);
      return $urandom_range(0, 1) ? (c & ~rgxpt_pkg::CASE_BIT) : c;
   endfunction

   function automatic void add_word(int unsigned len);
      repeat (len)
         text_buf.push_back(mixed_case(8'(rgxpt_pkg::CH_A_LOWER + $urandom_range(0, 25))));
   endfunction

   function automatic void add_digits(int unsigned len);
      repeat (len) text_buf.push_back(8'(rgxpt_pkg::CH_ZERO + $urandom_range(0, 9)));
   endfunction

   // Offers one item and returns at the edge where it is accepted.
   task automatic send_byte(logic [7:0] b, logic closing);
      int unsigned  gap_len;
      rgxpt_pkg::req_item_type item;
      if (burst_left == 0) begin
         gap_len = $urandom_range(0, gap_max);
         if (gap_len > 0) begin
            push <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      item.text_byte = b;
      item.last_byte = closing;
      req_data <= item;
      push     <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   // Sends the text in text_buf; at hold_at the sender waits for every span due.
   task automatic send_text(int hold_at);
      for (int i = 0; i < text_buf.size(); i++) begin
         if (i == hold_at) begin
            push <= 1'b0;
            @(posedge clock);
            while (sb.spans_due.size() != 0) @(posedge clock);
            burst_left = 0;
         end
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   task automatic drain_spans();
      push <= 1'b0;
      @(posedge clock);
      while (sb.spans_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // Sets the span limit, reads it back, then streams random texts under one idling profile.
   task automatic run_phase(logic [16:0] limit, int unsigned bytes, int unsigned gap,
                            int unsigned burst, int unsigned stall_odds,
                            int unsigned stall_len, bit hold_once);
      logic [7:0]  ws_set[4];
      logic [7:0]  lead;
      string       marks;
      string       suffixes[7];
      string       sfx;
      int unsigned sent;
      ws_set   = '{rgxpt_pkg::CH_SPACE, rgxpt_pkg::CH_TAB, rgxpt_pkg::CH_LF,
                   rgxpt_pkg::CH_CR};
      marks    = ".,!?-;:()";
      suffixes = '{"s", "t", "m", "d", "re", "ve", "ll"};
      sent     = 0;

      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {rgxpt_pkg::REG_SPAN_LIMIT, 2'b00};
      pwdata  <= 32'(limit);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.set_span_limit(limit);

      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(limit)) sb.report("span_limit readback", prdata, 32'(limit));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);

      gap_max   = gap;
      burst_max = burst;
      stall_pct = stall_odds;
      stall_max = stall_len;

      // Mostly well-formed tokens, with some noise bytes and broken contractions.
      while (sent < bytes) begin
         text_buf.delete();
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 11))
               0, 1: add_word($urandom_range(1, 6));
               2: begin
                  text_buf.push_back(rgxpt_pkg::CH_SPACE);
                  add_word($urandom_range(1, 5));
               end
               3: begin
                  lead = 8'($urandom_range(8'hC2, 8'hFF));
                  text_buf.push_back(lead);
                  repeat (lead < rgxpt_pkg::LEAD_THREE ? 1 :
                          lead < rgxpt_pkg::LEAD_FOUR ? 2 : 3)
                     text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
               end
               4: begin
                  text_buf.push_back(rgxpt_pkg::CH_APOS);
                  sfx = suffixes[$urandom_range(0, 6)];
                  for (int j = 0; j < sfx.len(); j++) text_buf.push_back(mixed_case(sfx[j]));
               end
               5: add_digits($urandom_range(1, 5));
               6: begin
                  text_buf.push_back(rgxpt_pkg::CH_SPACE);
                  add_digits($urandom_range(1, 4));
               end
               7: repeat ($urandom_range(1, 3)) text_buf.push_back(ws_set[$urandom_range(0, 3)]);
               8: text_buf.push_back(marks[$urandom_range(0, marks.len() - 1)]);
               9: text_buf.push_back(8'($urandom_range(0, 255)));
               10: begin
                  text_buf.push_back(rgxpt_pkg::CH_APOS);
                  text_buf.push_back(8'($urandom_range(0, 255)));
               end
               default: text_buf.push_back(rgxpt_pkg::CH_SPACE);
            endcase
         end
         send_text((hold_once && sent == 0) ? text_buf.size() / 2 : -1);
         sent += text_buf.size();
      end
      drain_spans();
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed texts with no idling on either side, at the reset span limit.
      // Short and folded long contractions, a lone apostrophe, a spaced digit group
      // split after three digits.
      text_buf = '{rgxpt_pkg::CH_APOS, rgxpt_pkg::CH_S, rgxpt_pkg::CH_APOS, 8'h56,
                   rgxpt_pkg::CH_E, rgxpt_pkg::CH_APOS, 8'h78, rgxpt_pkg::CH_SPACE,
                   8'h31, 8'h32, 8'h33, 8'h34, 8'h35};
      send_text(-1);
      // A zero byte, two- and three-byte UTF-8 letters, a spaced letter, a whitespace
      // run, and a four-byte lead cut short by the text end.
      text_buf = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, rgxpt_pkg::CH_SPACE, 8'h51,
                   rgxpt_pkg::CH_TAB, rgxpt_pkg::CH_LF, rgxpt_pkg::CH_CR, 8'hFF};
      send_text(-1);
      // An apostrophe and a space left pending when the text ends.
      text_buf = '{rgxpt_pkg::CH_APOS};
      send_text(-1);
      text_buf = '{rgxpt_pkg::CH_SPACE};
      send_text(-1);
      drain_spans();

      // Random texts under several span limits and idling profiles.
      run_phase(17'h10000, 90, 3, 12, 20, 6, 1'b1);
      run_phase(17'd1, 50, 8, 4, 50, 10, 1'b0);
      run_phase(17'd0, 15, 0, 16, 0, 1, 1'b0);
      run_phase(17'd2, 70, 2, 16, 30, 3, 1'b0);
      run_phase(17'd5, 80, 0, 16, 0, 1, 1'b0);
      run_phase(17'h10000, 80, 5, 8, 40, 12, 1'b0);

      if (sb.errors == 0 && sb.spans_due.size() == 0) begin
         $display("regex_style_pretokenizer regression: pass");
      end else begin
         $display("regex_style_pretokenizer regression: fail");
      end
      $finish;
   end

endmodule
